[sv/swmm_pkg.sv]
// shared types and constants for the sliding window min/max block
`default_nettype none

package swmm_pkg;

  localparam int DATA_W         = 32;
  localparam int LEN_W          = 7;
  localparam int WINDOW_MAX_DEF = 64;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    data_t sample;
    logic  restart;
  } in_t;

  typedef struct packed {
    data_t window_min;
    data_t window_max;
  } out_t;

  typedef struct packed {
    data_t lo;
    data_t hi;
  } mm_t;

  typedef struct packed {
    logic             shift;
    logic [LEN_W-1:0] len;
  } ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_t;

  localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  localparam mm_t MM_IDENT = '{lo: DATA_MAX, hi: DATA_MIN};

endpackage

`default_nettype wire

[sv/swmm_if.sv]
// valid/ready stream interfaces for samples and results
`default_nettype none

interface swmm_in_if import swmm_pkg::*; ();
  logic valid;
  logic ready;
  in_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface swmm_out_if import swmm_pkg::*; ();
  logic valid;
  logic ready;
  out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[sv/swmm_cell.sv]
// one window cell: holds a sample and folds it into the passing min/max
`default_nettype none

module swmm_cell import swmm_pkg::*; (
  input  wire        clk,
  input  wire        shift_en,
  input  wire        act,
  input  wire data_t sample_in,
  input  wire mm_t   part_in,
  output data_t      sample_q,
  output mm_t        part_q
);

  data_t sample_r;
  mm_t   part_r;
  mm_t   part_nxt;

  always_comb begin
    part_nxt = part_in;
    if (act) begin
      if (sample_r < part_in.lo) part_nxt.lo = sample_r;
      if (sample_r > part_in.hi) part_nxt.hi = sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      sample_r <= sample_in;
    end
    part_r <= part_nxt;
  end

  assign sample_q = sample_r;
  assign part_q   = part_r;

endmodule

`default_nettype wire

[sv/swmm_ctrl.sv]
// control: window length register, fill count, sequencing and result register
`default_nettype none

module swmm_ctrl import swmm_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              cfg_we,
  input  wire  [LEN_W-1:0] cfg_wdata,
  input  wire              in_valid,
  input  wire              in_restart,
  output logic             in_ready,
  output logic             out_valid,
  input  wire              out_ready,
  output out_t             out_data,
  input  wire mm_t         sel_part,
  output ctl_t             ctl
);

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] cfg_len_r;
  logic [LEN_W-1:0] fill_r, fill_nxt, fill_base;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] eff_len;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r;
  logic             take;
  logic             done;
  logic             load;

  always_comb begin
    eff_len = cfg_len_r;
    if (cfg_len_r == '0) eff_len = LEN_W'(1);
    if (32'(cfg_len_r) > WINDOW_MAX) eff_len = LEN_W'(WINDOW_MAX);
  end

  assign take = in_valid && in_ready;
  assign done = (cnt_r == eff_len);
  assign load = (state_r == ST_CALC) && done && (!out_valid_r || out_ready);

  always_comb begin
    fill_base = in_restart ? '0 : fill_r;
    fill_nxt  = fill_r;
    if (take) begin
      fill_nxt = (&fill_base) ? fill_base : fill_base + LEN_W'(1);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take && (fill_nxt >= eff_len)) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    ctl.shift = take;
    ctl.len   = eff_len;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
      end
      ST_CALC: begin
        if (!done) cnt_nxt = cnt_r + LEN_W'(1);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (load)      out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_len_r   <= LEN_W'(1);
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_len_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.window_min <= sel_part.lo;
      out_data_r.window_max <= sel_part.hi;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[sv/sliding_window_min_max.sv]
// sliding window min/max: a row of sample cells with a rippling min/max partial
// a sample that yields no result is taken and the next may follow at once
// a sample that yields a result: the partial ripples down the cells, moving one cell a cycle,
// until the pass count reaches len; then the result is registered and the next sample taken
// the result load, and so the next sample, waits out any stall on the result channel
// synchronous active-low reset: window empty, window_len 1, no result pending
`default_nettype none

module sliding_window_min_max import swmm_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              cfg_we,
  input  wire  [LEN_W-1:0] cfg_wdata,
  swmm_in_if.sink          in_ch,
  swmm_out_if.source       out_ch
);

  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  ctl_t             ctl;
  data_t            samples [WINDOW_MAX];
  mm_t              parts   [WINDOW_MAX];
  logic [IDX_W-1:0] sel;
  mm_t              sel_part;
  logic             in_ready;
  logic             out_valid;
  out_t             out_data;

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        swmm_cell u_cell (
          .clk       (clk),
          .shift_en  (ctl.shift),
          .act       (32'(ctl.len) > gi),
          .sample_in (in_ch.payload.sample),
          .part_in   (MM_IDENT),
          .sample_q  (samples[gi]),
          .part_q    (parts[gi])
        );
      end else begin : g_body
        swmm_cell u_cell (
          .clk       (clk),
          .shift_en  (ctl.shift),
          .act       (32'(ctl.len) > gi),
          .sample_in (samples[gi-1]),
          .part_in   (parts[gi-1]),
          .sample_q  (samples[gi]),
          .part_q    (parts[gi])
        );
      end
    end
  endgenerate

  assign sel      = IDX_W'(ctl.len - LEN_W'(1));
  assign sel_part = parts[sel];

  swmm_ctrl #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_ch.valid),
    .in_restart (in_ch.payload.restart),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_data),
    .sel_part   (sel_part),
    .ctl        (ctl)
  );

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_data;

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.payload.window_min <= out_ch.payload.window_max))
    else $error("window_min above window_max");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.len != '0) && (32'(ctl.len) <= WINDOW_MAX))
    else $error("effective window length out of range");

  a_result_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result appeared without a min/max pass");

  a_no_shift_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready && !in_ch.ready) |=> !ctl.shift)
    else $error("sample row shifted during a min/max pass");

endmodule

`default_nettype wire
